// File: rtl/smfd_pkg.sv
// Shared types, constants and the CRC-8 step for the sensor measurement frame decoder.
// No dependencies; used by every module of the block.
package smfd_pkg;

    // Byte positions inside one 9-byte response; IDLE waits for a start.
    localparam logic [3:0] POS_W0_HI  = 4'd0;
    localparam logic [3:0] POS_W0_LO  = 4'd1;
    localparam logic [3:0] POS_W0_CRC = 4'd2;
    localparam logic [3:0] POS_W1_HI  = 4'd3;
    localparam logic [3:0] POS_W1_LO  = 4'd4;
    localparam logic [3:0] POS_W1_CRC = 4'd5;
    localparam logic [3:0] POS_W2_HI  = 4'd6;
    localparam logic [3:0] POS_W2_LO  = 4'd7;
    localparam logic [3:0] POS_W2_CRC = 4'd8;
    localparam logic [3:0] POS_IDLE   = 4'd9;

    // CRC-8, polynomial x^8 + x^5 + x^4 + 1, MSB first.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Scaling constants of the conversions.
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [15:0] ROUND_HALF  = 16'd32767;
    localparam logic [15:0] FULL_SCALE  = 16'd65535;

    // Raw words of one checked frame.
    typedef struct packed {
        logic        ok;
        logic [15:0] co2;
        logic [15:0] raw_t;
        logic [15:0] raw_h;
    } frame_words_t;

    // Converted result of one frame.
    typedef struct packed {
        logic        ok;
        logic [15:0] co2;
        logic [14:0] temp;
        logic [13:0] hum;
    } meas_t;

    // One byte through the CRC-8 register, eight shift steps.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/smfd_frame.sv
// Byte tracker: position counter, running CRC per word and word capture.
// Depends on smfd_pkg; hands one frame_words_t per complete response.
module smfd_frame (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  logic [7:0]            rx_byte,
    input  logic                  frame_start,
    output logic                  res_valid,
    input  logic                  res_ready,
    output smfd_pkg::frame_words_t res
);

    logic [3:0]             pos_reg, pos_next;
    logic [7:0]             crc_reg, crc_next;
    logic                   fail_reg, fail_next;
    logic [15:0]            w0_reg, w0_next;
    logic [15:0]            w1_reg, w1_next;
    logic [15:0]            w2_reg, w2_next;
    logic                   res_valid_reg, res_valid_next;
    smfd_pkg::frame_words_t res_reg, res_next;
    logic                   byte_fire;

    // A byte can enter while the result slot is empty or draining.
    assign byte_ready = !res_valid_reg || res_ready;
    assign byte_fire  = byte_valid && byte_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // Next state for the tracker and the result slot.
    always_comb
    begin
        logic [3:0] pos_v;
        logic [7:0] crc_v;
        logic       fail_v;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        fail_next      = fail_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        pos_v          = pos_reg;
        crc_v          = crc_reg;
        fail_v         = fail_reg;
        if (frame_start)
        begin
            pos_v  = smfd_pkg::POS_W0_HI;
            crc_v  = smfd_pkg::CRC_INIT;
            fail_v = 1'b0;
        end
        if (byte_fire && (frame_start || pos_reg < smfd_pkg::POS_IDLE))
        begin
            case (pos_v)
                smfd_pkg::POS_W0_HI:
                begin
                    crc_v   = smfd_pkg::crc8_update(smfd_pkg::CRC_INIT, rx_byte);
                    w0_next = {rx_byte, 8'h00};
                end
                smfd_pkg::POS_W1_HI:
                begin
                    crc_v   = smfd_pkg::crc8_update(smfd_pkg::CRC_INIT, rx_byte);
                    w1_next = {rx_byte, 8'h00};
                end
                smfd_pkg::POS_W2_HI:
                begin
                    crc_v   = smfd_pkg::crc8_update(smfd_pkg::CRC_INIT, rx_byte);
                    w2_next = {rx_byte, 8'h00};
                end
                smfd_pkg::POS_W0_LO:
                begin
                    crc_v   = smfd_pkg::crc8_update(crc_v, rx_byte);
                    w0_next = {w0_reg[15:8], rx_byte};
                end
                smfd_pkg::POS_W1_LO:
                begin
                    crc_v   = smfd_pkg::crc8_update(crc_v, rx_byte);
                    w1_next = {w1_reg[15:8], rx_byte};
                end
                smfd_pkg::POS_W2_LO:
                begin
                    crc_v   = smfd_pkg::crc8_update(crc_v, rx_byte);
                    w2_next = {w2_reg[15:8], rx_byte};
                end
                smfd_pkg::POS_W0_CRC, smfd_pkg::POS_W1_CRC, smfd_pkg::POS_W2_CRC:
                begin
                    if (crc_v != rx_byte)
                    begin
                        fail_v = 1'b1;
                    end
                    crc_v = smfd_pkg::CRC_INIT;
                end
                default:
                begin
                    crc_v = smfd_pkg::CRC_INIT;
                end
            endcase
            crc_next  = crc_v;
            fail_next = fail_v;
            if (pos_v == smfd_pkg::POS_W2_CRC)
            begin
                // Last byte: the frame leaves as one result transfer.
                pos_next       = smfd_pkg::POS_IDLE;
                res_valid_next = 1'b1;
                res_next.ok    = !fail_v;
                res_next.co2   = w0_reg;
                res_next.raw_t = w1_reg;
                res_next.raw_h = w2_reg;
            end
            else
            begin
                pos_next = pos_v + 4'd1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= smfd_pkg::POS_IDLE;
            crc_reg       <= smfd_pkg::CRC_INIT;
            fail_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            fail_reg      <= fail_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Captured words and the result payload.
    always_ff @(posedge clk)
    begin
        w0_reg  <= w0_next;
        w1_reg  <= w1_next;
        w2_reg  <= w2_next;
        res_reg <= res_next;
    end

endmodule

// File: rtl/smfd_scale.sv
// Two-stage conversion: scale multiply, then the rounded divide by 65535 and offset.
// Depends on smfd_pkg; takes frame_words_t and gives meas_t through an output register.
module smfd_scale (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  smfd_pkg::frame_words_t in_words,
    output logic                   out_valid,
    input  logic                   out_ready,
    output smfd_pkg::meas_t        out_meas
);

    logic            s1_valid_reg, s1_valid_next;
    logic            s1_ok_reg;
    logic [15:0]     s1_co2_reg;
    logic [30:0]     s1_prod_t_reg, s1_prod_t_next;
    logic [29:0]     s1_prod_h_reg, s1_prod_h_next;
    logic            out_valid_reg, out_valid_next;
    smfd_pkg::meas_t out_reg, out_next;
    logic            s2_ready;
    logic            s1_load;
    logic            s2_load;
    logic [14:0]     qt_est;
    logic [16:0]     rt;
    logic [14:0]     qt;
    logic [13:0]     qh_est;
    logic [16:0]     rh;
    logic [13:0]     qh;

    // Each stage moves when the stage after it has room.
    assign s2_ready  = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s2_ready;
    assign s1_load   = in_valid && in_ready;
    assign s2_load   = s1_valid_reg && s2_ready;
    assign out_valid = out_valid_reg;
    assign out_meas  = out_reg;

    // Stage one: scale times raw word plus half of the divisor.
    assign s1_prod_t_next = 31'(smfd_pkg::TEMP_SCALE) * 31'(in_words.raw_t)
                          + 31'(smfd_pkg::ROUND_HALF);
    assign s1_prod_h_next = 30'(smfd_pkg::HUM_SCALE) * 30'(in_words.raw_h)
                          + 30'(smfd_pkg::ROUND_HALF);
    assign s1_valid_next  = s1_load || (s1_valid_reg && !s2_ready);

    // Stage two: x / 65535 from x >> 16 with one correction step,
    // since the remainder estimate stays below twice the divisor.
    assign qt_est = s1_prod_t_reg[30:16];
    assign rt     = {1'b0, s1_prod_t_reg[15:0]} + 17'(qt_est);
    assign qt     = qt_est + 15'(rt >= 17'(smfd_pkg::FULL_SCALE));
    assign qh_est = s1_prod_h_reg[29:16];
    assign rh     = {1'b0, s1_prod_h_reg[15:0]} + 17'(qh_est);
    assign qh     = qh_est + 14'(rh >= 17'(smfd_pkg::FULL_SCALE));

    // A failed check clears all value fields.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (s2_load)
        begin
            out_valid_next = 1'b1;
            out_next.ok    = s1_ok_reg;
            if (s1_ok_reg)
            begin
                out_next.co2  = s1_co2_reg;
                out_next.temp = qt - smfd_pkg::TEMP_OFFSET;
                out_next.hum  = qh;
            end
            else
            begin
                out_next.co2  = '0;
                out_next.temp = '0;
                out_next.hum  = '0;
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_ok_reg     <= in_words.ok;
            s1_co2_reg    <= in_words.co2;
            s1_prod_t_reg <= s1_prod_t_next;
            s1_prod_h_reg <= s1_prod_h_next;
        end
        out_reg <= out_next;
    end

endmodule

// File: rtl/sensor_measurement_frame_decoder.sv
// Sensor measurement frame decoder: one byte per cycle in, one measurement per frame out.
// A frame's result passes the tracker, multiply and output registers to the master side.
// Throughput: one byte per cycle; only a held result that is not taken stalls the input.
// Reset (rst_n, asynchronous, active low) leaves the tracker idle awaiting a frame start.
// Structure: byte tracker register, multiply register, divide and output register.
// Depends on smfd_pkg, smfd_frame and smfd_scale.
module sensor_measurement_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] co2_ppm, [30:16] temp_centi_deg,
                                   // [44:31] hum_centi_pct, [47:45] zero
    output logic        m_tuser    // [0] frame_ok
);

    smfd_pkg::frame_words_t words;
    logic                   words_valid;
    logic                   words_ready;
    smfd_pkg::meas_t        meas;

    // Byte tracking and CRC check.
    smfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (s_tvalid),
        .byte_ready  (s_tready),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .res_valid   (words_valid),
        .res_ready   (words_ready),
        .res         (words)
    );

    // Unit conversion and output register.
    smfd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (words_valid),
        .in_ready  (words_ready),
        .in_words  (words),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_meas  (meas)
    );

    // Pack the result fields.
    assign m_tdata = {3'b000, meas.hum, meas.temp, meas.co2};
    assign m_tuser = meas.ok;

    // A failed frame carries all-zero values.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 48'd0))
    else $error("failed frame with nonzero values");

    // Humidity of a passing frame never exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[44:31] <= 14'd10000))
    else $error("humidity above full scale");

    // The input stalls only when a result is held on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
    else $error("input stalled without a pending result");

endmodule

// File: tb/frame_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the sensor measurement frame decoder testbench: a byte-level
// predictor of the decoder and the queue of measurements it still owes.
// Depends on smfd_pkg for the measurement type and the protocol constants.
package frame_check_pkg;
    import smfd_pkg::*;

    class frame_scoreboard;
        // Predicted tracker state, updated on every accepted input transfer.
        logic [3:0]  byte_pos;
        logic [7:0]  crc_acc;
        logic [15:0] words [3];
        logic        crc_failed;

        // Measurements predicted but not yet seen on the master side.
        meas_t       owed_q [$];
        int          mismatches;

        function new();
            byte_pos   = POS_IDLE;
            crc_acc    = CRC_INIT;
            words      = '{16'h0000, 16'h0000, 16'h0000};
            crc_failed = 1'b0;
            mismatches = 0;
        endfunction

        // CRC-8 over one byte, MSB first, no reflection.
        static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            repeat (8)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
            return c;
        endfunction

        // Advances the prediction by one accepted byte. Returns 0 when the
        // decoder ignores the byte (idle and no start flag).
        function bit note_byte(logic [7:0] b, logic start);
            int unsigned idx;
            int unsigned word;
            int unsigned part;
            int unsigned t_q;
            int unsigned h_q;
            logic [31:0] t_c;
            meas_t       m;
            if (start)
            begin
                byte_pos   = POS_W0_HI;
                crc_acc    = CRC_INIT;
                crc_failed = 1'b0;
            end
            else if (byte_pos >= POS_IDLE)
                return 1'b0;

            idx  = byte_pos;
            word = idx / 3;
            part = idx % 3;
            case (part)
                0:
                begin
                    crc_acc     = crc8_step(CRC_INIT, b);
                    words[word] = {b, 8'h00};
                end
                1:
                begin
                    crc_acc          = crc8_step(crc_acc, b);
                    words[word][7:0] = b;
                end
                default:
                begin
                    if (crc_acc != b)
                        crc_failed = 1'b1;
                    crc_acc = CRC_INIT;
                end
            endcase

            if (byte_pos != POS_W2_CRC)
            begin
                byte_pos = byte_pos + 4'd1;
                return 1'b1;
            end

            // Ninth byte: the frame closes and one measurement is owed.
            byte_pos = POS_IDLE;
            m = '0;
            if (!crc_failed)
            begin
                t_q    = (32'(TEMP_SCALE) * 32'(words[1]) + 32'(ROUND_HALF)) / 32'(FULL_SCALE);
                h_q    = (32'(HUM_SCALE) * 32'(words[2]) + 32'(ROUND_HALF)) / 32'(FULL_SCALE);
                t_c    = t_q - 32'(TEMP_OFFSET);
                m.ok   = 1'b1;
                m.co2  = words[0];
                m.temp = t_c[14:0];
                m.hum  = h_q[13:0];
            end
            owed_q.push_back(m);
            return 1'b1;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s", $realtime, what);
        endfunction

        // Compares one accepted result transfer with the oldest owed measurement.
        function void check_result(logic [47:0] data, logic ok_flag);
            meas_t want;
            if (owed_q.size() == 0)
            begin
                flag_mismatch($sformatf("result with none expected, tdata=0x%h tuser=%b",
                                        data, ok_flag));
                return;
            end
            want = owed_q.pop_front();
            if (ok_flag !== want.ok)
                flag_mismatch($sformatf("frame_ok expected %b, got %b", want.ok, ok_flag));
            if (data[15:0] !== want.co2)
                flag_mismatch($sformatf("co2_ppm expected %0d, got %0d", want.co2, data[15:0]));
            if (data[30:16] !== want.temp)
                flag_mismatch($sformatf("temp_centi_deg expected %0d, got %0d",
                                        $signed(want.temp), $signed(data[30:16])));
            if (data[44:31] !== want.hum)
                flag_mismatch($sformatf("hum_centi_pct expected %0d, got %0d",
                                        want.hum, data[44:31]));
            if (data[47:45] !== 3'b000)
                flag_mismatch($sformatf("tdata padding expected 0, got %b", data[47:45]));
        endfunction
    endclass

endpackage

// File: tb/tb_sensor_measurement_frame_decoder.sv
`timescale 1ns / 100ps
// Top-level testbench of the sensor measurement frame decoder: drives byte
// transfers with random gaps and back-pressure, checks every measurement.
// Depends on smfd_pkg, frame_check_pkg and the decoder RTL.
module tb_sensor_measurement_frame_decoder;
    import smfd_pkg::*;
    import frame_check_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int BYTE_TARGET  = 1750;
    localparam int IDLE_PCT     = 19;
    localparam int STALL_LIMIT  = 2000;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 1000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    // Set while both sides run without any idling.
    logic        quiet    = 1'b0;
    int          bytes_taken  = 0;
    int          stall_cycles = 0;

    frame_scoreboard sb = new();

    always #(CLK_PERIOD / 2) clk = ~clk;

    sensor_measurement_frame_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Result side: check each transfer and apply random back-pressure.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: too long without any transfer on either side ends the run.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One byte transfer, preceded by random idling unless quiet is set.
    task automatic send_byte(input logic [7:0] b, input logic start);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        if (sb.note_byte(b, start))
            bytes_taken++;
    endtask

    // Sends the first n_bytes of a response built from three words; a set bit
    // in bad_crc corrupts that word's CRC byte.
    task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1,
                              input logic [15:0] w2, input logic [2:0] bad_crc,
                              input int n_bytes);
        logic [15:0] w [3];
        logic [7:0]  frame_bytes [9];
        logic [7:0]  c;
        w = '{w0, w1, w2};
        for (int i = 0; i < 3; i++)
        begin
            c = frame_scoreboard::crc8_step(frame_scoreboard::crc8_step(CRC_INIT, w[i][15:8]),
                                            w[i][7:0]);
            if (bad_crc[i])
                c = c ^ 8'($urandom_range(1, 255));
            frame_bytes[3 * i]     = w[i][15:8];
            frame_bytes[3 * i + 1] = w[i][7:0];
            frame_bytes[3 * i + 2] = c;
        end
        for (int i = 0; i < n_bytes; i++)
            send_byte(frame_bytes[i], i == 0);
    endtask

    // Raw words lean toward the ends of the range.
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int          pick;
        logic [2:0]  bad_crc;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle byte, full-scale frame, dropped frame, failed check,
        // byte after the ninth, all-zero frame.
        send_byte(8'h5A, 1'b0);
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, 9);
        send_frame(16'h1234, 16'h5678, 16'h9ABC, 3'b000, 2);
        send_frame(16'h8001, 16'h7FFE, 16'h4000, 3'b010, 9);
        send_byte(8'hFF, 1'b0);
        send_frame(16'h0000, 16'h0000, 16'h0000, 3'b000, 9);

        // Random: mostly complete frames, some broken frames and noise.
        while (bytes_taken < BYTE_TARGET)
        begin
            quiet <= (bytes_taken >= QUIET_FIRST) && (bytes_taken < QUIET_LAST);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                bad_crc = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
                send_frame(rand_word(), rand_word(), rand_word(), bad_crc, 9);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end
            else if (pick < 85)
            begin
                bad_crc = 3'($urandom_range(0, 7));
                send_frame(rand_word(), rand_word(), rand_word(), bad_crc,
                           $urandom_range(1, 8));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end
        s_tvalid <= 1'b0;

        // Drain the owed measurements, then allow for the pipeline latency.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
